// ----- hdl/byte_trie_prefix_index_core_defines.svh -----
// Assertion macros for the byte trie prefix index checker.
// Depends on nothing; included by the checker file only.
`ifndef BYTE_TRIE_PREFIX_INDEX_CORE_DEFINES_SVH
`define BYTE_TRIE_PREFIX_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BTPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btpi port check failed");

// Next-cycle implication, sampled on clk, off during reset
`define BTPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btpi port check failed");

`endif

// ----- hdl/btpi_pkg.sv -----
// Shared types, codes and helpers for the byte trie prefix index.
// No dependencies; imported by the core, the checker and the bench.
package btpi_pkg;

    localparam int DEF_POOL_NODES     = 2048;
    localparam int DEF_FANOUT         = 16;
    localparam int DEF_MAX_CANDIDATES = 32;
    localparam int SIG_LEN            = 6;
    localparam logic [15:0] EMPTY_ID  = 16'hFFFF;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  sig_byte_0;
        logic [7:0]  sig_byte_1;
        logic [7:0]  sig_byte_2;
        logic [7:0]  sig_byte_3;
        logic [7:0]  sig_byte_4;
        logic [7:0]  sig_byte_5;
        logic [15:0] entry_id;
        logic [2:0]  prefix_len;
    } cmd_t;

    typedef struct packed {
        logic        op_ok;
        logic        cand_valid;
        logic [15:0] cand_id;
        logic        last_result;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHK,
        ST_ADDP,
        ST_ADDC,
        ST_FIN,
        ST_DFS_NODE,
        ST_DFS_RD,
        ST_POP,
        ST_END
    } state_t;

    // Pick the signature byte for a trie layer
    function automatic logic [7:0] sig_at(cmd_t c, logic [2:0] lvl);
        logic [7:0] b;
        unique case (lvl)
            3'd0: b = c.sig_byte_0;
            3'd1: b = c.sig_byte_1;
            3'd2: b = c.sig_byte_2;
            3'd3: b = c.sig_byte_3;
            3'd4: b = c.sig_byte_4;
            3'd5: b = c.sig_byte_5;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic res_t mk_res(logic ok, logic cv, logic [15:0] id, logic last);
        res_t r;
        r.op_ok       = ok;
        r.cand_valid  = cv;
        r.cand_id     = id;
        r.last_result = last;
        return r;
    endfunction

endpackage

// ----- hdl/btpi_node_ram.sv -----
// Single-port-write, registered-read node pool memory.
// Depends on nothing; instantiated by the trie index core.
module btpi_node_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one node
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one node into the output register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/byte_trie_prefix_index_core.sv -----
// Byte trie prefix index: insert, prefix query with depth-first collection, delete.
// Insert/delete scan the child slots of each layer, an insert creates each missing node
//   (decide, parent write, child write), the id at depth six is stored or cleared, then the
//   result beat follows; a query walks the subtree depth first, reading each subtree node,
//   stepping to siblings or dropping frames, then closes. One node memory port; one command at a time.
// Results are strobed one cycle each, the receiver cannot stall. Reset empties the root
//   and sets the free pointer to 1; no memory sweep needed.
module byte_trie_prefix_index_core
    import btpi_pkg::*;
#(
    parameter int POOL_NODES     = DEF_POOL_NODES,
    parameter int FANOUT         = DEF_FANOUT,
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic res_valid,
    output res_t res
);

    localparam int AW = $clog2(POOL_NODES);
    localparam int CW = $clog2(FANOUT + 1);
    localparam int KW = $clog2(MAX_CANDIDATES + 1);
    localparam int NW = 8 + 16 + CW + AW;
    localparam int FW = AW + 2;
    localparam int SW = $clog2(SIG_LEN);

    state_t state_reg, state_next;
    cmd_t   op_reg, op_next;
    logic [2:0]    lvl_reg, lvl_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [7:0]    cur_byte_reg, cur_byte_next;
    logic [15:0]   cur_id_reg, cur_id_next;
    logic [CW-1:0] cur_cnt_reg, cur_cnt_next;
    logic [AW-1:0] cur_base_reg, cur_base_next;
    logic [AW-1:0] tmp_addr_reg, tmp_addr_next;
    logic [AW-1:0] free_reg, free_next;
    logic [15:0]   root_id_reg, root_id_next;
    logic [CW-1:0] root_cnt_reg, root_cnt_next;
    logic [AW-1:0] root_base_reg, root_base_next;
    logic [AW-1:0] stk_base_reg [SIG_LEN];
    logic [CW-1:0] stk_cnt_reg [SIG_LEN];
    logic [CW-1:0] stk_idx_reg [SIG_LEN];
    logic [2:0]    sp_reg, sp_next;
    logic [KW-1:0] cand_reg, cand_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [15:0]   pend_id_reg, pend_id_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    // Memory ports
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [NW-1:0] rd_data;
    logic          wr_go;
    logic [AW-1:0] wr_addr;
    logic [NW-1:0] wr_data;

    // Stack push/update controls
    logic          push_en, upd_en;
    logic [SW-1:0] top;

    // Decoded read data
    logic [7:0]    rd_byte;
    logic [15:0]   rd_id;
    logic [CW-1:0] rd_cnt;
    logic [AW-1:0] rd_base;

    // Decision terms
    logic          is_ins, is_qry, cmd_bad, at_tgt, scan, add_ok, chk_hit;
    logic          leaf, cand_full, pop_more;
    logic [2:0]    tgt;
    logic [7:0]    sig_cur;
    logic [AW-1:0] base_n;
    logic [CW-1:0] pop_idx;

    assign rd_byte = rd_data[NW-1 -: 8];
    assign rd_id   = rd_data[NW-9 -: 16];
    assign rd_cnt  = rd_data[AW+CW-1 -: CW];
    assign rd_base = rd_data[AW-1:0];

    assign is_ins  = (op_reg.func == FUNC_INSERT);
    assign is_qry  = (op_reg.func == FUNC_QUERY);
    assign cmd_bad = !(is_ins || is_qry || op_reg.func == FUNC_DELETE)
                     || (is_qry && (op_reg.prefix_len == 3'd0 || op_reg.prefix_len == 3'd7));
    assign tgt     = is_qry ? op_reg.prefix_len : 3'(SIG_LEN);
    assign at_tgt  = (lvl_reg == tgt);
    assign scan    = (idx_reg < cur_cnt_reg);
    assign add_ok  = !(cur_cnt_reg == '0
                       && ({2'b00, free_reg} + FW'(FANOUT) >= FW'(POOL_NODES)))
                     && (cur_cnt_reg < CW'(FANOUT));
    assign sig_cur = sig_at(op_reg, lvl_reg);
    assign chk_hit = (rd_byte == sig_cur);
    assign base_n  = (cur_cnt_reg == '0) ? free_reg : cur_base_reg;
    assign leaf    = (cur_cnt_reg == '0);
    assign cand_full = ({1'b0, cand_reg} + (KW+1)'(1) == (KW+1)'(MAX_CANDIDATES));
    assign top     = SW'(sp_reg - 3'd1);
    assign pop_idx = stk_idx_reg[top] + CW'(1);
    assign pop_more = (pop_idx < stk_cnt_reg[top]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_WALK;
            ST_WALK:
            begin
                priority if (cmd_bad)           state_next = ST_IDLE;
                else if (at_tgt && is_qry)      state_next = ST_DFS_NODE;
                else if (at_tgt)                state_next = ST_FIN;
                else if (scan)                  state_next = ST_CHK;
                else if (is_ins && add_ok)      state_next = ST_ADDP;
                else                            state_next = ST_IDLE;
            end
            ST_CHK:      state_next = ST_WALK;
            ST_ADDP:     state_next = ST_ADDC;
            ST_ADDC:     state_next = ST_WALK;
            ST_FIN:      state_next = ST_IDLE;
            ST_DFS_NODE:
            begin
                priority if (leaf && cand_full) state_next = ST_END;
                else if (leaf)                  state_next = ST_POP;
                else                            state_next = ST_DFS_RD;
            end
            ST_DFS_RD:   state_next = ST_DFS_NODE;
            ST_POP:
            begin
                priority if (sp_reg == 3'd0)    state_next = ST_END;
                else if (pop_more)              state_next = ST_DFS_RD;
                else                            state_next = ST_POP;
            end
            ST_END:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory accesses and result beats
    always_comb
    begin
        op_next         = op_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        cur_addr_next   = cur_addr_reg;
        cur_byte_next   = cur_byte_reg;
        cur_id_next     = cur_id_reg;
        cur_cnt_next    = cur_cnt_reg;
        cur_base_next   = cur_base_reg;
        tmp_addr_next   = tmp_addr_reg;
        free_next       = free_reg;
        root_id_next    = root_id_reg;
        root_cnt_next   = root_cnt_reg;
        root_base_next  = root_base_reg;
        sp_next         = sp_reg;
        cand_next       = cand_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        res_valid_next  = 1'b0;
        res_next        = mk_res(1'b0, 1'b0, 16'd0, 1'b0);
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_go           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        push_en         = 1'b0;
        upd_en          = 1'b0;

        unique case (state_reg)
            // Latch the command and start at the root
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = cmd;
                    lvl_next      = 3'd0;
                    idx_next      = '0;
                    cur_addr_next = '0;
                    cur_byte_next = 8'd0;
                    cur_id_next   = root_id_reg;
                    cur_cnt_next  = root_cnt_reg;
                    cur_base_next = root_base_reg;
                end
            end
            // Scan the next child slot or decide
            ST_WALK:
            begin
                priority if (cmd_bad || (!at_tgt && !scan && !(is_ins && add_ok)))
                begin
                    res_valid_next = 1'b1;
                    res_next       = mk_res(1'b0, 1'b0, 16'd0, 1'b1);
                end
                else if (at_tgt && is_qry)
                begin
                    sp_next         = 3'd0;
                    cand_next       = '0;
                    pend_valid_next = 1'b0;
                end
                else if (at_tgt)
                begin
                end
                else if (scan)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = cur_base_reg + AW'(idx_reg);
                    tmp_addr_next = rd_addr;
                end
                else
                begin
                end
            end
            // Compare the fetched child byte
            ST_CHK:
            begin
                if (chk_hit)
                begin
                    cur_addr_next = tmp_addr_reg;
                    cur_byte_next = rd_byte;
                    cur_id_next   = rd_id;
                    cur_cnt_next  = rd_cnt;
                    cur_base_next = rd_base;
                    lvl_next      = lvl_reg + 3'd1;
                    idx_next      = '0;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            // Grow the parent: take a block if first child, bump count
            ST_ADDP:
            begin
                if (cur_cnt_reg == '0)
                begin
                    free_next = free_reg + AW'(FANOUT);
                end
                wr_go         = 1'b1;
                wr_addr       = cur_addr_reg;
                wr_data       = {cur_byte_reg, cur_id_reg, cur_cnt_reg + CW'(1), base_n};
                tmp_addr_next = base_n + AW'(cur_cnt_reg);
            end
            // Write the fresh child and descend into it
            ST_ADDC:
            begin
                wr_go         = 1'b1;
                wr_addr       = tmp_addr_reg;
                wr_data       = {sig_cur, EMPTY_ID, CW'(0), AW'(0)};
                cur_addr_next = tmp_addr_reg;
                cur_byte_next = sig_cur;
                cur_id_next   = EMPTY_ID;
                cur_cnt_next  = '0;
                cur_base_next = '0;
                lvl_next      = lvl_reg + 3'd1;
                idx_next      = '0;
            end
            // Store or clear the leaf id
            ST_FIN:
            begin
                wr_go          = 1'b1;
                wr_addr        = cur_addr_reg;
                wr_data        = {cur_byte_reg, is_ins ? op_reg.entry_id : EMPTY_ID,
                                  cur_cnt_reg, cur_base_reg};
                res_valid_next = 1'b1;
                res_next       = mk_res(1'b1, 1'b0, 16'd0, 1'b1);
            end
            // Visit a subtree node: collect a leaf or descend
            ST_DFS_NODE:
            begin
                if (leaf)
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = mk_res(1'b1, 1'b1, pend_id_reg, 1'b0);
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = cur_id_reg;
                    cand_next       = cand_reg + KW'(1);
                end
                else
                begin
                    push_en       = 1'b1;
                    sp_next       = sp_reg + 3'd1;
                    rd_en         = 1'b1;
                    rd_addr       = cur_base_reg;
                    tmp_addr_next = cur_base_reg;
                end
            end
            // Take the fetched child as the current node
            ST_DFS_RD:
            begin
                cur_addr_next = tmp_addr_reg;
                cur_byte_next = rd_byte;
                cur_id_next   = rd_id;
                cur_cnt_next  = rd_cnt;
                cur_base_next = rd_base;
            end
            // Advance to the next sibling or drop a frame
            ST_POP:
            begin
                if (sp_reg != 3'd0)
                begin
                    if (pop_more)
                    begin
                        upd_en        = 1'b1;
                        rd_en         = 1'b1;
                        rd_addr       = stk_base_reg[top] + AW'(pop_idx);
                        tmp_addr_next = rd_addr;
                    end
                    else
                    begin
                        sp_next = sp_reg - 3'd1;
                    end
                end
            end
            // Flush the held candidate, if any, as the final beat
            ST_END:
            begin
                res_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    res_next = mk_res(1'b1, 1'b1, pend_id_reg, 1'b1);
                end
                else
                begin
                    res_next = mk_res(1'b1, 1'b0, 16'd0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase

        // Root lives in flops rather than the pool
        if (wr_go && wr_addr == '0)
        begin
            root_id_next   = wr_data[NW-9 -: 16];
            root_cnt_next  = wr_data[AW+CW-1 -: CW];
            root_base_next = wr_data[AW-1:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_reg       <= AW'(1);
            root_id_reg    <= EMPTY_ID;
            root_cnt_reg   <= '0;
            root_base_reg  <= '0;
            sp_reg         <= 3'd0;
            cand_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_reg       <= free_next;
            root_id_reg    <= root_id_next;
            root_cnt_reg   <= root_cnt_next;
            root_base_reg  <= root_base_next;
            sp_reg         <= sp_next;
            cand_reg       <= cand_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        cur_addr_reg <= cur_addr_next;
        cur_byte_reg <= cur_byte_next;
        cur_id_reg   <= cur_id_next;
        cur_cnt_reg  <= cur_cnt_next;
        cur_base_reg <= cur_base_next;
        tmp_addr_reg <= tmp_addr_next;
        pend_id_reg  <= pend_id_next;
        res_reg      <= res_next;
        if (push_en)
        begin
            stk_base_reg[SW'(sp_reg)] <= cur_base_reg;
            stk_cnt_reg[SW'(sp_reg)]  <= cur_cnt_reg;
            stk_idx_reg[SW'(sp_reg)]  <= '0;
        end
        if (upd_en)
        begin
            stk_idx_reg[top] <= pop_idx;
        end
    end

    btpi_node_ram #(
        .DEPTH (POOL_NODES),
        .WIDTH (NW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_go && wr_addr != '0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hdl/btpi_checker.sv -----
// Port-level checker for the byte trie prefix index, bound to the top level.
// Depends on btpi_pkg and byte_trie_prefix_index_core_defines.svh.
`include "byte_trie_prefix_index_core_defines.svh"
module btpi_checker
    import btpi_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic res_valid,
    input res_t res
);

    // An accepted command holds the block busy next cycle
    `BTPI_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    // A beat without a candidate closes its command
    `BTPI_ASSERT_NOW(a_empty_is_last, res_valid && !res.cand_valid, res.last_result)
    // A beat without a candidate carries a zero id
    `BTPI_ASSERT_NOW(a_empty_zero_id, res_valid && !res.cand_valid, res.cand_id == 16'd0)
    // Candidates only follow a matched prefix
    `BTPI_ASSERT_NOW(a_cand_ok, res_valid && res.cand_valid, res.op_ok)

endmodule

bind byte_trie_prefix_index_core btpi_checker u_chk (.*);

// ----- bench/byte_trie_prefix_index_core_test.sv -----
// Self-checking bench for the byte trie prefix index: a queue-fed command driver,
// a result monitor and a trie model built in the bench that predicts each result.
// Depends on btpi_pkg and byte_trie_prefix_index_core.
`timescale 1ns / 100ps

module byte_trie_prefix_index_core_test;
    import btpi_pkg::*;

    localparam int POOL      = DEF_POOL_NODES;
    localparam int FAN       = DEF_FANOUT;
    localparam int MAXC      = DEF_MAX_CANDIDATES;
    localparam int NONE      = -1;
    localparam int IDLE_LIM  = 20000;
    localparam int N_RANDOM  = 64;
    localparam int N_FILL    = 32;

    typedef enum int { PH_FLAT, PH_SEND_IDLE, PH_RECV_IDLE, PH_BOTH } phase_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic res_valid;
    res_t res;

    byte_trie_prefix_index_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    // Trie model state
    logic [7:0]  trie_byte [POOL];
    logic [15:0] trie_id   [POOL];
    int          trie_count[POOL];
    int          trie_base [POOL];
    int          alloc_ptr;

    cmd_t   pending_cmds[$];
    res_t   expected_res[$];
    cmd_t   sig_pool[$];
    phase_t phase;
    int     errors;
    int     quiet_cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int child_of(int p, logic [7:0] b);
        for (int i = 0; i < trie_count[p] && i < FAN; i++)
            if (trie_base[p] + i < POOL && trie_byte[trie_base[p] + i] == b)
                return trie_base[p] + i;
        return NONE;
    endfunction

    function automatic int grow_child(int p, logic [7:0] b);
        int c;
        c = child_of(p, b);
        if (c != NONE) return c;
        if (trie_count[p] == 0) begin
            if (alloc_ptr + FAN >= POOL) return NONE;
            trie_base[p] = alloc_ptr;
            alloc_ptr += FAN;
        end
        if (trie_count[p] >= FAN) return NONE;
        c = trie_base[p] + trie_count[p];
        trie_byte[c] = b;
        trie_id[c] = EMPTY_ID;
        trie_count[c] = 0;
        trie_base[c] = 0;
        trie_count[p]++;
        return c;
    endfunction

    // Depth-first leaf collection, capped at the candidate limit
    function automatic void gather_leaves(int n, int depth, ref logic [15:0] ids[$]);
        if (ids.size() >= MAXC || depth > SIG_LEN) return;
        if (trie_count[n] == 0) begin
            ids.push_back(trie_id[n]);
            return;
        end
        for (int i = 0; i < trie_count[n] && i < FAN && ids.size() < MAXC; i++)
            gather_leaves(trie_base[n] + i, depth + 1, ids);
    endfunction

    // Apply one command to the model and queue the results it yields
    function automatic void predict_trie(cmd_t c);
        int n;
        logic [15:0] ids[$];
        n = 0;
        if (c.func == FUNC_INSERT) begin
            for (int i = 0; i < SIG_LEN && n != NONE; i++)
                n = grow_child(n, sig_at(c, i[2:0]));
            if (n != NONE) trie_id[n] = c.entry_id;
            expected_res.push_back(mk_res(n != NONE, 1'b0, 16'd0, 1'b1));
        end else if (c.func == FUNC_DELETE) begin
            for (int i = 0; i < SIG_LEN && n != NONE; i++)
                n = child_of(n, sig_at(c, i[2:0]));
            if (n != NONE) trie_id[n] = EMPTY_ID;
            expected_res.push_back(mk_res(n != NONE, 1'b0, 16'd0, 1'b1));
        end else if (c.func == FUNC_QUERY && c.prefix_len >= 1 && c.prefix_len <= SIG_LEN) begin
            for (int i = 0; i < c.prefix_len && n != NONE; i++)
                n = child_of(n, sig_at(c, i[2:0]));
            if (n == NONE)
                expected_res.push_back(mk_res(1'b0, 1'b0, 16'd0, 1'b1));
            else begin
                gather_leaves(n, c.prefix_len, ids);
                if (ids.size() == 0)
                    expected_res.push_back(mk_res(1'b1, 1'b0, 16'd0, 1'b1));
                foreach (ids[i])
                    expected_res.push_back(mk_res(1'b1, 1'b1, ids[i], i == ids.size() - 1));
            end
        end else
            expected_res.push_back(mk_res(1'b0, 1'b0, 16'd0, 1'b1));
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] f, logic [47:0] sig, logic [15:0] id,
                                      logic [2:0] plen);
        cmd_t c;
        c.func = f;
        {c.sig_byte_0, c.sig_byte_1, c.sig_byte_2, c.sig_byte_3, c.sig_byte_4,
         c.sig_byte_5} = sig;
        c.entry_id = id;
        c.prefix_len = plen;
        return c;
    endfunction

    // Signature drawn from a few shared stems so paths overlap and fanout fills
    function automatic logic [47:0] rand_sig();
        logic [47:0] s;
        s = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: s[47:40] = 8'h00;
            1: s[47:32] = {8'hFF, 8'h10};
            2: s[47:24] = {8'hA5, 8'h5A, 8'($urandom_range(0, 20))};
            default: ;
        endcase
        return s;
    endfunction

    // Driver: hold start until accepted, idle at random in the sender phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            cmd   <= '0;
        end else if (!(start && busy)) begin
            if (start) begin
                predict_trie(cmd);
                void'(pending_cmds.pop_front());
            end
            if (pending_cmds.size() > 0 &&
                !((phase == PH_SEND_IDLE && $urandom_range(0, 99) < 60) ||
                  (phase == PH_BOTH && $urandom_range(0, 99) < 19))) begin
                start <= 1'b1;
                cmd   <= pending_cmds[0];
            end else
                start <= 1'b0;
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid) begin
            if (expected_res.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                res_t e;
                e = expected_res.pop_front();
                if (res.op_ok !== e.op_ok) begin
                    $error("op_ok expected %0d got %0d", e.op_ok, res.op_ok); errors++;
                end
                if (res.cand_valid !== e.cand_valid) begin
                    $error("cand_valid expected %0d got %0d", e.cand_valid, res.cand_valid);
                    errors++;
                end
                if (res.cand_id !== e.cand_id) begin
                    $error("cand_id expected %0h got %0h", e.cand_id, res.cand_id); errors++;
                end
                if (res.last_result !== e.last_result) begin
                    $error("last_result expected %0d got %0d", e.last_result,
                           res.last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIM) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [47:0] s;
        logic [47:0] stem;
        cmd_t c;
        errors = 0;
        quiet_cycles = 0;
        phase = PH_FLAT;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        for (int i = 0; i < POOL; i++) begin
            trie_count[i] = 0; trie_base[i] = 0; trie_id[i] = 16'd0; trie_byte[i] = 8'd0;
        end
        trie_id[0] = EMPTY_ID;
        alloc_ptr = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty trie, extremes, duplicates, deletes, bad prefixes, fanout full
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'h0, 16'd1, 3'd1));
        pending_cmds.push_back(make_cmd(FUNC_DELETE, 48'h0, 16'd0, 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_INSERT, 48'h0, 16'h0000, 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_INSERT, '1, 16'hFFFF, 3'd7));
        pending_cmds.push_back(make_cmd(FUNC_INSERT, 48'hFF00FF00FF00, 16'h1234, 3'd6));
        pending_cmds.push_back(make_cmd(FUNC_INSERT, 48'h0, 16'hBEEF, 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'hFF0000000000, 16'd0, 3'd1));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, '1, 16'd0, 3'd6));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'h0, 16'd0, 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'h0, 16'd0, 3'd7));
        pending_cmds.push_back(make_cmd(FUNC_DELETE, '1, 16'd0, 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, '1, 16'd0, 3'd3));
        pending_cmds.push_back(make_cmd(FUNC_DELETE, 48'h123456789ABC, 16'd0, 3'd0));
        pending_cmds.push_back(make_cmd(2'd3, '1, 16'hFFFF, 3'd2));
        // Seventeen children under one stem: the last overflows the fanout
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(FUNC_INSERT, {40'h77_66_55_44_33, 8'(i * 15)},
                                            16'(i), 3'd0));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'h776655443300, 16'd0, 3'd5));
        pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'h0, 16'd0, 3'd0 + 3'd0 + 3'd1));

        // Random phases; most commands reuse inserted signatures
        for (int ph = 0; ph < 4; ph++) begin
            wait (pending_cmds.size() == 0 && expected_res.size() == 0 && !start);
            phase = phase_t'(ph);
            // Fill the pool half way through so the nearly-full case is reached
            if (ph == 2) begin
                for (int i = 0; i < N_FILL; i++) begin
                    stem = {8'hC3 + 8'(i / 16), 8'(i % 16), 8'($urandom), 8'($urandom),
                            8'h00, 8'h00};
                    pending_cmds.push_back(make_cmd(FUNC_INSERT, stem, 16'(i), 3'd0));
                end
                pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'hC30000000000, 16'd0, 3'd1));
                pending_cmds.push_back(make_cmd(FUNC_QUERY, 48'hC30000000000, 16'd0, 3'd2));
            end
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (sig_pool.size() > 0 && $urandom_range(0, 99) < 65)
                    s = {sig_pool[$urandom_range(0, sig_pool.size() - 1)].sig_byte_0,
                         sig_pool[0].sig_byte_1, 32'h0};
                if (sig_pool.size() > 0 && $urandom_range(0, 99) < 65) begin
                    c = sig_pool[$urandom_range(0, sig_pool.size() - 1)];
                    s = {c.sig_byte_0, c.sig_byte_1, c.sig_byte_2, c.sig_byte_3,
                         c.sig_byte_4, c.sig_byte_5};
                end else
                    s = rand_sig();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c = make_cmd(FUNC_INSERT, s, 16'($urandom), 3'd0);
                    4, 5, 6:    c = make_cmd(FUNC_QUERY, s, 16'($urandom),
                                             3'($urandom_range(1, 6)));
                    7, 8:       c = make_cmd(FUNC_DELETE, s, 16'($urandom), 3'($urandom));
                    default:    c = make_cmd(2'($urandom), s, 16'($urandom), 3'($urandom));
                endcase
                if (c.func == FUNC_INSERT) sig_pool.push_back(c);
                pending_cmds.push_back(c);
            end
        end

        wait (pending_cmds.size() == 0 && !start);
        wait (expected_res.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- byte_trie_prefix_index_core.f -----
+incdir+hdl
hdl/btpi_pkg.sv
hdl/btpi_node_ram.sv
hdl/byte_trie_prefix_index_core.sv
hdl/btpi_checker.sv
bench/byte_trie_prefix_index_core_test.sv
